>>> src/hbridge_speed_to_pwm_mapper_assert.svh
// ----------------------------------------------------------------------------
// hbridge_speed_to_pwm_mapper_assert.svh
// Assertion macros used by the mapper's checker.
// ----------------------------------------------------------------------------
`ifndef HBRIDGE_SPEED_TO_PWM_MAPPER_ASSERT_SVH
`define HBRIDGE_SPEED_TO_PWM_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HSM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define HSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hsm_pkg.sv
// ----------------------------------------------------------------------------
// hsm_pkg
// Types, widths and constants of the H-bridge speed-to-PWM mapper.
// ----------------------------------------------------------------------------
package hsm_pkg;

    localparam int NUM_MOTORS = 3;

    localparam int SPAN_W     = 15;
    localparam int FULL_W     = 16;
    localparam int DB_W       = 8;
    localparam int MASK_W     = 3;
    localparam int CMD_W      = 16;
    localparam int MOTOR_W    = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Quotient of mag*full/span stays at or below 2*full, so 18 bits cover it.
    localparam int QUO_W      = 18;
    localparam int PROD_W     = 31;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    // front, multiply, divider stages, output register
    localparam int NUM_STAGES = DIV_STAGES + 3;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 15'd1000;
    localparam logic [FULL_W-1:0] FULL_RESET = 16'd1000;
    localparam logic [DB_W-1:0]   DB_RESET   = 8'd10;
    localparam logic [MASK_W-1:0] MASK_RESET = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_SPAN   = 2'd0,
        REG_PWM_FULL     = 2'd1,
        REG_DEAD_BAND    = 2'd2,
        REG_REVERSE_MASK = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_BIDIR  = 1'b0,
        ACT_UNIDIR = 1'b1
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [MOTOR_W-1:0]  motor;
        logic                brake;
        logic                fwd_raw;
        logic [SPAN_W-1:0]   uni_val;
    } side_t;

    typedef struct packed {
        side_t               side;
        logic [FULL_W-1:0]   mag;
    } front_t;

    typedef struct packed {
        side_t               side;
        logic [SPAN_W-1:0]   rem;
        logic [QUO_W-1:0]    acc;
    } div_t;

    function automatic logic motor_reversed(logic [MASK_W-1:0] mask, logic [MOTOR_W-1:0] m);
        logic rev;
        rev = 1'b0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (i < NUM_MOTORS && m == MOTOR_W'(i))
            begin
                rev = mask[i];
            end
        end
        return rev;
    endfunction

endpackage

>>> src/hsm_front.sv
// ----------------------------------------------------------------------------
// hsm_front
// Deadzones, centring and magnitude of a speed command; first pipe stage.
// ----------------------------------------------------------------------------
module hsm_front (
    input  logic                                clk,
    input  logic                                en,
    input  logic                                action,
    input  logic [hsm_pkg::MOTOR_W-1:0]         motor_select,
    input  logic signed [hsm_pkg::CMD_W-1:0]    speed_command,
    input  logic [hsm_pkg::SPAN_W-1:0]          speed_span,
    input  logic [hsm_pkg::DB_W-1:0]            dead_band,
    output hsm_pkg::front_t                     stage_out
);

    hsm_pkg::front_t    stage_reg;
    hsm_pkg::front_t    stage_next;

    logic signed [17:0] cmd_s;
    logic signed [17:0] span_s;
    logic signed [17:0] db_s;
    logic signed [17:0] half_s;
    logic signed [17:0] hi_s;
    logic signed [17:0] v_bi;
    logic signed [17:0] v_uni;
    logic signed [17:0] diff;
    logic signed [17:0] diff_abs;
    logic               unidir;

    assign unidir = (hsm_pkg::action_t'(action) == hsm_pkg::ACT_UNIDIR);

    always_comb
    begin
        cmd_s  = {{2{speed_command[15]}}, speed_command};
        span_s = {3'b000, speed_span};
        db_s   = {10'd0, dead_band};
        half_s = {4'b0000, speed_span[14:1]};
        hi_s   = span_s - db_s;

        // bidirectional: end deadzones only, upper one wins
        v_bi = cmd_s;
        if (cmd_s < db_s)
        begin
            v_bi = 18'sd0;
        end
        if (cmd_s > hi_s)
        begin
            v_bi = span_s;
        end

        // unidirectional: centre, then lower end, then upper end
        v_uni = cmd_s;
        if (cmd_s > half_s - db_s && cmd_s < half_s + db_s)
        begin
            v_uni = half_s;
        end
        if (cmd_s < db_s)
        begin
            v_uni = 18'sd0;
        end
        if (cmd_s > hi_s)
        begin
            v_uni = span_s;
        end

        diff     = v_bi - half_s;
        diff_abs = (diff < 18'sd0) ? -diff : diff;

        stage_next.side.action  = hsm_pkg::action_t'(action);
        stage_next.side.motor   = motor_select;
        stage_next.side.brake   = unidir ? (v_uni <= 18'sd0) : (diff == 18'sd0);
        stage_next.side.fwd_raw = unidir ? 1'b1 : (diff > 18'sd0);
        stage_next.side.uni_val = v_uni[14:0];
        // centred value is twice the offset; |offset| fits 15 bits
        stage_next.mag          = {diff_abs[14:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> src/hsm_mult.sv
// ----------------------------------------------------------------------------
// hsm_mult
// Multiplies the magnitude by the full-scale PWM value and seeds the divider.
// ----------------------------------------------------------------------------
module hsm_mult (
    input  logic                         clk,
    input  logic                         en,
    input  hsm_pkg::front_t              stage_in,
    input  logic [hsm_pkg::FULL_W-1:0]   pwm_full,
    output hsm_pkg::div_t                stage_out
);

    hsm_pkg::div_t               stage_reg;
    hsm_pkg::div_t               stage_next;
    logic [hsm_pkg::PROD_W-1:0]  prod;

    always_comb
    begin
        // product is below 2^31; upper bits start the partial remainder
        prod = hsm_pkg::PROD_W'({{hsm_pkg::FULL_W{1'b0}}, stage_in.mag} *
                                {{hsm_pkg::FULL_W{1'b0}}, pwm_full});
        stage_next.side = stage_in.side;
        stage_next.rem  = {2'b00, prod[hsm_pkg::PROD_W-1:hsm_pkg::QUO_W]};
        stage_next.acc  = prod[hsm_pkg::QUO_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> src/hsm_div_stage.sv
// ----------------------------------------------------------------------------
// hsm_div_stage
// One stage of the restoring divider by speed_span, two quotient bits.
// ----------------------------------------------------------------------------
module hsm_div_stage (
    input  logic                         clk,
    input  logic                         en,
    input  hsm_pkg::div_t                stage_in,
    input  logic [hsm_pkg::SPAN_W-1:0]   speed_span,
    output hsm_pkg::div_t                stage_out
);

    hsm_pkg::div_t  stage_reg;
    hsm_pkg::div_t  stage_next;

    always_comb
    begin : div_step
        logic [hsm_pkg::SPAN_W:0]   trial;
        logic [hsm_pkg::SPAN_W-1:0] rem;
        logic [hsm_pkg::QUO_W-1:0]  acc;
        rem = stage_in.rem;
        acc = stage_in.acc;
        // acc shifts dividend bits out at the top and quotient bits in below
        for (int s = 0; s < hsm_pkg::DIV_STEPS; s++)
        begin
            trial = {rem, acc[hsm_pkg::QUO_W-1]};
            acc   = {acc[hsm_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, speed_span})
            begin
                rem    = hsm_pkg::SPAN_W'(trial - {1'b0, speed_span});
                acc[0] = 1'b1;
            end
            else
            begin
                rem = trial[hsm_pkg::SPAN_W-1:0];
            end
        end
        stage_next      = stage_in;
        stage_next.rem  = rem;
        stage_next.acc  = acc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> src/hsm_out.sv
// ----------------------------------------------------------------------------
// hsm_out
// Saturation, direction and duty selection; holds the result register.
// ----------------------------------------------------------------------------
module hsm_out (
    input  logic                          clk,
    input  logic                          en,
    input  hsm_pkg::div_t                 stage_in,
    input  logic [hsm_pkg::FULL_W-1:0]    pwm_full,
    input  logic [hsm_pkg::MASK_W-1:0]    reverse_mask,
    output logic [hsm_pkg::MOTOR_W-1:0]   motor_index,
    output logic [hsm_pkg::FULL_W-1:0]    duty_back,
    output logic [hsm_pkg::FULL_W-1:0]    duty_fwd,
    output logic                          braking,
    output logic                          forward
);

    logic [hsm_pkg::MOTOR_W-1:0] motor_reg, motor_next;
    logic [hsm_pkg::FULL_W-1:0]  back_reg, back_next;
    logic [hsm_pkg::FULL_W-1:0]  fwd_duty_reg, fwd_duty_next;
    logic                        braking_reg, braking_next;
    logic                        forward_reg, forward_next;

    logic [hsm_pkg::QUO_W-1:0]   sp;
    logic [hsm_pkg::FULL_W-1:0]  sat;
    logic                        dir_fwd;

    always_comb
    begin
        sp = (stage_in.side.action == hsm_pkg::ACT_UNIDIR) ?
             {3'b000, stage_in.side.uni_val} : stage_in.acc;
        sat = (sp > {2'b00, pwm_full}) ? pwm_full : sp[hsm_pkg::FULL_W-1:0];
        dir_fwd = stage_in.side.fwd_raw ^
                  hsm_pkg::motor_reversed(reverse_mask, stage_in.side.motor);

        motor_next = stage_in.side.motor;
        if (stage_in.side.brake)
        begin
            back_next     = pwm_full;
            fwd_duty_next = pwm_full;
            braking_next  = 1'b1;
            forward_next  = 1'b0;
        end
        else
        begin
            back_next     = dir_fwd ? pwm_full : (pwm_full - sat);
            fwd_duty_next = dir_fwd ? (pwm_full - sat) : pwm_full;
            braking_next  = 1'b0;
            forward_next  = dir_fwd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            motor_reg    <= motor_next;
            back_reg     <= back_next;
            fwd_duty_reg <= fwd_duty_next;
            braking_reg  <= braking_next;
            forward_reg  <= forward_next;
        end
    end

    assign motor_index = motor_reg;
    assign duty_back   = back_reg;
    assign duty_fwd    = fwd_duty_reg;
    assign braking     = braking_reg;
    assign forward     = forward_reg;

endmodule

>>> src/hbridge_speed_to_pwm_mapper.sv
// ----------------------------------------------------------------------------
// hbridge_speed_to_pwm_mapper
// Maps speed commands to IN/IN H-bridge duty pairs through a 12-stage pipe.
// ----------------------------------------------------------------------------
// Takes one command per clock unless out_ready stalls a full pipe, and
// passes it through the stages in order: one for deadzones and centring,
// one for the 16x16 multiply, nine for the restoring divider by speed_span
// (two quotient bits per stage), one for saturation and the output register.
// Each stage moves on when the stage after it is empty or moving, so
// bubbles are squeezed out while the output waits. Configuration writes
// take effect at once and must only be made with the pipe empty.
module hbridge_speed_to_pwm_mapper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [hsm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hsm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [hsm_pkg::MOTOR_W-1:0]          motor_select,
    input  logic signed [hsm_pkg::CMD_W-1:0]     speed_command,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [hsm_pkg::MOTOR_W-1:0]          motor_index,
    output logic [hsm_pkg::FULL_W-1:0]           duty_back,
    output logic [hsm_pkg::FULL_W-1:0]           duty_fwd,
    output logic                                 braking,
    output logic                                 forward
);

    localparam int NST = hsm_pkg::NUM_STAGES;
    localparam int NDS = hsm_pkg::DIV_STAGES;

    logic [hsm_pkg::SPAN_W-1:0] span_reg;
    logic [hsm_pkg::FULL_W-1:0] full_reg;
    logic [hsm_pkg::DB_W-1:0]   db_reg;
    logic [hsm_pkg::MASK_W-1:0] mask_reg;

    logic [NST-1:0]  valid_reg;
    logic [NST-1:0]  valid_next;
    logic [NST-1:0]  stage_en;

    hsm_pkg::front_t front_q;
    hsm_pkg::div_t   div_chain [NDS+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= hsm_pkg::SPAN_RESET;
            full_reg <= hsm_pkg::FULL_RESET;
            db_reg   <= hsm_pkg::DB_RESET;
            mask_reg <= hsm_pkg::MASK_RESET;
        end
        else if (cfg_write)
        begin
            case (hsm_pkg::cfg_reg_t'(cfg_index))
                hsm_pkg::REG_SPEED_SPAN:   span_reg <= cfg_data[hsm_pkg::SPAN_W-1:0];
                hsm_pkg::REG_PWM_FULL:     full_reg <= cfg_data[hsm_pkg::FULL_W-1:0];
                hsm_pkg::REG_DEAD_BAND:    db_reg   <= cfg_data[hsm_pkg::DB_W-1:0];
                hsm_pkg::REG_REVERSE_MASK: mask_reg <= cfg_data[hsm_pkg::MASK_W-1:0];
                default:                   ;
            endcase
        end
    end

    // stage i may load when any stage from i up to the output is empty,
    // or when the output register is being drained
    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            stage_en[i] = out_ready || ((valid_reg | NST'((1 << i) - 1)) != '1);
        end
        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NST-1];

    hsm_front u_front (
        .clk           (clk),
        .en            (stage_en[0]),
        .action        (action),
        .motor_select  (motor_select),
        .speed_command (speed_command),
        .speed_span    (span_reg),
        .dead_band     (db_reg),
        .stage_out     (front_q)
    );

    hsm_mult u_mult (
        .clk       (clk),
        .en        (stage_en[1]),
        .stage_in  (front_q),
        .pwm_full  (full_reg),
        .stage_out (div_chain[0])
    );

    for (genvar k = 0; k < NDS; k++)
    begin : g_div
        hsm_div_stage u_div (
            .clk        (clk),
            .en         (stage_en[k+2]),
            .stage_in   (div_chain[k]),
            .speed_span (span_reg),
            .stage_out  (div_chain[k+1])
        );
    end

    hsm_out u_out (
        .clk          (clk),
        .en           (stage_en[NST-1]),
        .stage_in     (div_chain[NDS]),
        .pwm_full     (full_reg),
        .reverse_mask (mask_reg),
        .motor_index  (motor_index),
        .duty_back    (duty_back),
        .duty_fwd     (duty_fwd),
        .braking      (braking),
        .forward      (forward)
    );

endmodule

>>> src/hsm_checker.sv
// ----------------------------------------------------------------------------
// hsm_checker
// Port-level checks of the speed-to-PWM mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "hbridge_speed_to_pwm_mapper_assert.svh"

module hsm_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [hsm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hsm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 action,
    input  logic [hsm_pkg::MOTOR_W-1:0]          motor_select,
    input  logic signed [hsm_pkg::CMD_W-1:0]     speed_command,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [hsm_pkg::MOTOR_W-1:0]          motor_index,
    input  logic [hsm_pkg::FULL_W-1:0]           duty_back,
    input  logic [hsm_pkg::FULL_W-1:0]           duty_fwd,
    input  logic                                 braking,
    input  logic                                 forward
);

    // a brake drives both bridge inputs at the same full value
    `HSM_ASSERT_IMPL(a_brake_equal, out_valid && braking, (duty_back == duty_fwd) && !forward, "brake result with unequal duties or forward set")

    // the side that is not switching sits at full, so it is never the lower
    `HSM_ASSERT_IMPL(a_fwd_order, out_valid && !braking && forward, duty_back >= duty_fwd, "forward drive with duty_back below duty_fwd")

    `HSM_ASSERT_IMPL(a_back_order, out_valid && !braking && !forward, duty_fwd >= duty_back, "backward drive with duty_fwd below duty_back")

    // the pipe always has room once the output slot is free or draining
    `HSM_ASSERT_IMPL(a_ready_free, !out_valid || out_ready, in_ready, "input stalled with output slot free")

    `HSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty_back) && $stable(duty_fwd) && $stable(motor_index), "stalled result changed")

endmodule

bind hbridge_speed_to_pwm_mapper hsm_checker u_hsm_checker (.*);
